// ===== design/fnpll_pkg.sv =====
// Shared widths, constants and register indexes of the PLL divider solver.
package fnpll_pkg;

  localparam int unsigned FREQ_W   = 33;
  localparam int unsigned REF_W    = 28;
  localparam int unsigned SPC_W    = 24;
  localparam int unsigned CHSPC_W  = 25;
  localparam int unsigned RMAX_W   = 10;
  localparam int unsigned R_W      = 11;
  localparam int unsigned NUM_W    = 39;
  localparam int unsigned PFDM_W   = 35;
  localparam int unsigned PFD_W    = 25;
  localparam int unsigned INT_W    = 16;
  localparam int unsigned FR_W     = 12;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned DVS_W    = 30;
  localparam int unsigned DCNT_W   = 6;
  localparam int unsigned MPL_W    = 39;
  localparam int unsigned SH_W     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  localparam logic [FREQ_W-1:0] F_MAX     = 33'd4400000000;
  localparam logic [FREQ_W-1:0] F_MIN     = 33'd137500000;
  localparam logic [FREQ_W-1:0] VCO_MIN   = 33'd2200000000;
  localparam logic [FREQ_W-1:0] HIGH_TH   = 33'd3000000000;
  localparam logic [DVD_W-1:0]  PFDM_MAX  = 64'd32000000999;
  localparam logic [DVD_W-1:0]  MAX_MODULUS = 64'd4095;
  localparam logic [R_W-1:0]    MAX_R_COUNT = 11'd1023;
  localparam logic [DVD_W-1:0]  MDIV_HIGH = 64'd75;
  localparam logic [DVD_W-1:0]  MDIV_LOW  = 64'd23;
  localparam logic [DVS_W-1:0]  MILLI     = 30'd1000;
  localparam logic [DVS_W-1:0]  BAND_DIV  = 30'd125000;
  localparam logic [PFD_W-1:0]  BAND_RND  = 25'd124999;
  localparam logic [DVS_W-1:0]  GIGA      = 30'd1000000000;
  localparam logic [MPL_W-1:0]  MEGA      = 39'd1000000;
  localparam logic [DVD_W-1:0]  BAND_SAT  = 64'd255;

  localparam logic [REF_W-1:0]   RST_REF  = 28'd25000000;
  localparam logic [SPC_W-1:0]   RST_SPC  = 24'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_CLOCK  = 3'd0,
    CFG_CH_SPACING = 3'd1,
    CFG_REF_DBL    = 3'd2,
    CFG_REF_HALF   = 3'd3,
    CFG_MAX_R      = 3'd4
  } cfg_idx_e;

endpackage

// ===== design/fnpll_if.sv =====
// Handshake channels of the PLL divider solver: request, result and configuration.
interface fnpll_in_if;
  logic                               valid;
  logic                               ready;
  logic [fnpll_pkg::FREQ_W-1:0]       freq_hz;
  modport source (output valid, output freq_hz, input ready);
  modport sink   (input valid, input freq_hz, output ready);
endinterface

interface fnpll_out_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic [fnpll_pkg::INT_W-1:0]        int_value;
  logic [fnpll_pkg::FR_W-1:0]         fract_value;
  logic [fnpll_pkg::FR_W-1:0]         modulus;
  logic [fnpll_pkg::RMAX_W-1:0]       r_count;
  logic [2:0]                         rf_div_select;
  logic                               prescaler_high;
  logic [7:0]                         band_select_div;
  logic [fnpll_pkg::FREQ_W-1:0]       vco_freq_hz;
  logic [fnpll_pkg::PFD_W-1:0]        pfd_hz;
  logic [fnpll_pkg::FREQ_W-1:0]       actual_freq_hz;
  modport source (output valid, output accepted, output int_value, output fract_value,
                  output modulus, output r_count, output rf_div_select,
                  output prescaler_high, output band_select_div, output vco_freq_hz,
                  output pfd_hz, output actual_freq_hz, input ready);
  modport sink   (input valid, input accepted, input int_value, input fract_value,
                  input modulus, input r_count, input rf_div_select,
                  input prescaler_high, input band_select_div, input vco_freq_hz,
                  input pfd_hz, input actual_freq_hz, output ready);
endinterface

interface fnpll_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [fnpll_pkg::CFG_IDX_W-1:0]    index;
  logic [fnpll_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fnpll_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module fnpll_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [fnpll_pkg::DVD_W-1:0]      dividend_i,
  input  logic [fnpll_pkg::DVS_W-1:0]      divisor_i,
  output logic                             done_o,
  output logic [fnpll_pkg::DVD_W-1:0]      quotient_o,
  output logic [fnpll_pkg::DVS_W-1:0]      remainder_o
);

  logic [fnpll_pkg::DVD_W-1:0]  quo_q, quo_d;
  logic [fnpll_pkg::DVS_W-1:0]  rem_q, rem_d, dvs_q;
  logic [fnpll_pkg::DCNT_W-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [fnpll_pkg::DVS_W:0]    shifted, trial;
  logic                         ge;

  always_comb begin
    shifted = {rem_q, quo_q[fnpll_pkg::DVD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? trial[fnpll_pkg::DVS_W-1:0] : shifted[fnpll_pkg::DVS_W-1:0];
    quo_d   = {quo_q[fnpll_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      cnt_q  <= '1;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== design/frac_n_pll_divider_solver_top.sv =====
// Top level of the fractional-N PLL divider solver: sequencer, shift-add multiplier, GCD.
//
// Channels: in_i takes one requested output frequency per item; out_o returns one
// result item per request; cfg_i writes the five setup registers (index, data) and
// is always ready. Write configuration only while no request is in flight.
// in_i is ready only when the solver is idle; an item occupies it until its result
// has been moved into the output register, which then waits for out_o.ready while
// the next request is already taken.
// A rejected request goes from S_IDLE through S_FIN into the output register once that
// register is free. An accepted one runs through a shared radix-2 divider and a
// bit-serial multiplier (one multiplier bit per cycle): up to three divisions for each R
// counter step, plus up to 7 divisions, 4 multiplications and the GCD (one shift or
// subtract per cycle) at the end. A request takes longer when R is raised many times or
// the channel spacing has to be increased. The divider is the pacing unit.
// Reset restores the register defaults (25 MHz reference, 1 kHz spacing, no doubler,
// no halver, no R limit) and empties the output register.
module frac_n_pll_divider_solver_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  fnpll_in_if.sink      in_i,
  fnpll_out_if.source   out_o,
  fnpll_cfg_if.sink     cfg_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DBL, S_RINC, S_RPFD, S_RHZ, S_RMOD, S_NADD, S_NSPLIT, S_NCHK,
    S_GEVEN, S_GAODD, S_GLOOP, S_GMOD, S_GFR, S_BAND, S_AMUL1, S_ADIV1, S_AMUL2,
    S_AMUL3, S_ASHR, S_FIN, S_WDIV, S_WMUL
  } state_e;

  state_e state_q, ret_q;

  logic [fnpll_pkg::REF_W-1:0]   ref_q;
  logic [fnpll_pkg::SPC_W-1:0]   spc_q;
  logic                          dbl_q, hlv_q;
  logic [fnpll_pkg::RMAX_W-1:0]  maxr_q;

  logic [fnpll_pkg::FREQ_W-1:0]  vco_q;
  logic [2:0]                    rfdiv_q;
  logic                          high_q, ok_q;
  logic [fnpll_pkg::NUM_W-1:0]   num_q;
  logic [fnpll_pkg::CHSPC_W-1:0] chspc_q;
  logic [fnpll_pkg::R_W-1:0]     r_q;
  logic [fnpll_pkg::PFDM_W-1:0]  pfdm_q;
  logic [fnpll_pkg::PFD_W-1:0]   pfd_q;
  logic [fnpll_pkg::CHSPC_W-1:0] mod_q, fract_q, ga_q, gb_q, g_q;
  logic [fnpll_pkg::INT_W-1:0]   nint_q;
  logic [fnpll_pkg::SH_W-1:0]    gsh_q;
  logic [7:0]                    band_q;
  logic [fnpll_pkg::DVD_W-1:0]   sum_q;

  logic [fnpll_pkg::DVD_W-1:0]   dva_q;
  logic [fnpll_pkg::DVS_W-1:0]   dvb_q;
  logic                          div_go_q, div_done;
  logic [fnpll_pkg::DVD_W-1:0]   div_quo;
  logic [fnpll_pkg::DVS_W-1:0]   div_rem;

  logic [fnpll_pkg::DVD_W-1:0]   acc_q, mcand_q;
  logic [fnpll_pkg::MPL_W-1:0]   mplier_q;

  logic                          out_valid_q;
  logic                          out_acc_q, out_high_q;
  logic [fnpll_pkg::INT_W-1:0]   out_int_q;
  logic [fnpll_pkg::FR_W-1:0]    out_fract_q, out_mod_q;
  logic [fnpll_pkg::RMAX_W-1:0]  out_r_q;
  logic [2:0]                    out_rfdiv_q;
  logic [7:0]                    out_band_q;
  logic [fnpll_pkg::FREQ_W-1:0]  out_vco_q, out_act_q;
  logic [fnpll_pkg::PFD_W-1:0]   out_pfd_q;

  logic [fnpll_pkg::NUM_W-1:0]   ref_milli;
  logic [fnpll_pkg::R_W-1:0]     r_next;
  logic [2*fnpll_pkg::CHSPC_W-1:0] g_wide;
  logic                          out_free;

  fnpll_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_go_q),
    .dividend_i  (dva_q),
    .divisor_i   (dvb_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    ref_milli = ({11'd0, ref_q} << 10) - ({11'd0, ref_q} << 4) - ({11'd0, ref_q} << 3);
    r_next    = r_q + 1'b1;
    g_wide    = {{fnpll_pkg::CHSPC_W{1'b0}}, ga_q} << gsh_q;
    out_free  = !out_valid_q || out_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= fnpll_pkg::RST_REF;
      spc_q  <= fnpll_pkg::RST_SPC;
      dbl_q  <= 1'b0;
      hlv_q  <= 1'b0;
      maxr_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        fnpll_pkg::CFG_REF_CLOCK:  ref_q  <= cfg_i.data;
        fnpll_pkg::CFG_CH_SPACING: spc_q  <= cfg_i.data[fnpll_pkg::SPC_W-1:0];
        fnpll_pkg::CFG_REF_DBL:    dbl_q  <= cfg_i.data[0];
        fnpll_pkg::CFG_REF_HALF:   hlv_q  <= cfg_i.data[0];
        fnpll_pkg::CFG_MAX_R:      maxr_q <= cfg_i.data[fnpll_pkg::RMAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      vco_q    <= '0;
      rfdiv_q  <= '0;
      high_q   <= 1'b0;
      ok_q     <= 1'b0;
      num_q    <= '0;
      chspc_q  <= '0;
      r_q      <= '0;
      pfdm_q   <= '0;
      pfd_q    <= '0;
      mod_q    <= '0;
      fract_q  <= '0;
      ga_q     <= '0;
      gb_q     <= '0;
      g_q      <= '0;
      nint_q   <= '0;
      gsh_q    <= '0;
      band_q   <= '0;
      sum_q    <= '0;
      dva_q    <= '0;
      dvb_q    <= '0;
      div_go_q <= 1'b0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_high_q  <= 1'b0;
      out_int_q   <= '0;
      out_fract_q <= '0;
      out_mod_q   <= '0;
      out_r_q     <= '0;
      out_rfdiv_q <= '0;
      out_band_q  <= '0;
      out_vco_q   <= '0;
      out_act_q   <= '0;
      out_pfd_q   <= '0;
    end else begin
      div_go_q <= 1'b0;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            vco_q   <= in_i.freq_hz;
            rfdiv_q <= '0;
            high_q  <= in_i.freq_hz > fnpll_pkg::HIGH_TH;
            num_q   <= ref_milli << dbl_q;
            chspc_q <= (spc_q == '0) ? 25'd1 : {1'b0, spc_q};
            r_q     <= '0;
            if (in_i.freq_hz > fnpll_pkg::F_MAX || in_i.freq_hz < fnpll_pkg::F_MIN) begin
              ok_q    <= 1'b0;
              state_q <= S_FIN;
            end else begin
              state_q <= S_DBL;
            end
          end
        end
        S_DBL: begin
          if (vco_q < fnpll_pkg::VCO_MIN) begin
            vco_q   <= vco_q << 1;
            rfdiv_q <= rfdiv_q + 1'b1;
          end else begin
            state_q <= S_RINC;
          end
        end
        S_RINC: begin
          r_q      <= r_next;
          dva_q    <= {25'd0, num_q};
          dvb_q    <= {18'd0, r_next, 1'b0} >> !hlv_q;
          div_go_q <= 1'b1;
          ret_q    <= S_RPFD;
          state_q  <= S_WDIV;
        end
        S_RPFD: begin
          if (div_quo > fnpll_pkg::PFDM_MAX) begin
            state_q <= S_RINC;
          end else begin
            pfdm_q   <= div_quo[fnpll_pkg::PFDM_W-1:0];
            dva_q    <= div_quo;
            dvb_q    <= fnpll_pkg::MILLI;
            div_go_q <= 1'b1;
            ret_q    <= S_RHZ;
            state_q  <= S_WDIV;
          end
        end
        S_RHZ: begin
          pfd_q    <= div_quo[fnpll_pkg::PFD_W-1:0];
          dva_q    <= div_quo;
          dvb_q    <= {5'd0, chspc_q};
          div_go_q <= 1'b1;
          ret_q    <= S_RMOD;
          state_q  <= S_WDIV;
        end
        S_RMOD: begin
          mod_q <= div_quo[fnpll_pkg::CHSPC_W-1:0];
          if (r_q > fnpll_pkg::MAX_R_COUNT) begin
            chspc_q <= chspc_q + 1'b1;
            r_q     <= '0;
            state_q <= S_RINC;
          end else if (div_quo > fnpll_pkg::MAX_MODULUS &&
                       (maxr_q == '0 || r_q < {1'b0, maxr_q})) begin
            state_q <= S_RINC;
          end else if (div_quo == '0) begin
            ok_q    <= 1'b0;
            state_q <= S_FIN;
          end else begin
            acc_q    <= '0;
            mcand_q  <= {31'd0, vco_q};
            mplier_q <= {14'd0, div_quo[fnpll_pkg::CHSPC_W-1:0]};
            ret_q    <= S_NADD;
            state_q  <= S_WMUL;
          end
        end
        S_NADD: begin
          dva_q    <= acc_q + {39'd0, pfd_q >> 1};
          dvb_q    <= {5'd0, pfd_q};
          div_go_q <= 1'b1;
          ret_q    <= S_NSPLIT;
          state_q  <= S_WDIV;
        end
        S_NSPLIT: begin
          dva_q    <= div_quo;
          dvb_q    <= {5'd0, mod_q};
          div_go_q <= 1'b1;
          ret_q    <= S_NCHK;
          state_q  <= S_WDIV;
        end
        S_NCHK: begin
          nint_q  <= div_quo[fnpll_pkg::INT_W-1:0];
          fract_q <= div_rem[fnpll_pkg::CHSPC_W-1:0];
          ga_q    <= mod_q;
          gb_q    <= div_rem[fnpll_pkg::CHSPC_W-1:0];
          gsh_q   <= '0;
          if ((high_q ? fnpll_pkg::MDIV_HIGH : fnpll_pkg::MDIV_LOW) > div_quo) begin
            state_q <= S_RINC;
          end else if (div_quo[fnpll_pkg::DVD_W-1:fnpll_pkg::INT_W] != '0) begin
            ok_q    <= 1'b0;
            state_q <= S_FIN;
          end else if (div_rem == '0) begin
            mod_q   <= 25'd1;
            state_q <= S_BAND;
          end else begin
            state_q <= S_GEVEN;
          end
        end
        S_GEVEN: begin
          if (ga_q[0] || gb_q[0]) begin
            state_q <= S_GAODD;
          end else begin
            ga_q  <= ga_q >> 1;
            gb_q  <= gb_q >> 1;
            gsh_q <= gsh_q + 1'b1;
          end
        end
        S_GAODD: begin
          if (ga_q[0]) begin
            state_q <= S_GLOOP;
          end else begin
            ga_q <= ga_q >> 1;
          end
        end
        S_GLOOP: begin
          if (gb_q == '0) begin
            g_q      <= g_wide[fnpll_pkg::CHSPC_W-1:0];
            dva_q    <= {39'd0, mod_q};
            dvb_q    <= {5'd0, g_wide[fnpll_pkg::CHSPC_W-1:0]};
            div_go_q <= 1'b1;
            ret_q    <= S_GMOD;
            state_q  <= S_WDIV;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q > gb_q) begin
            ga_q <= gb_q;
            gb_q <= ga_q - gb_q;
          end else begin
            gb_q <= gb_q - ga_q;
          end
        end
        S_GMOD: begin
          mod_q    <= div_quo[fnpll_pkg::CHSPC_W-1:0];
          dva_q    <= {39'd0, fract_q};
          dvb_q    <= {5'd0, g_q};
          div_go_q <= 1'b1;
          ret_q    <= S_GFR;
          state_q  <= S_WDIV;
        end
        S_GFR: begin
          fract_q <= div_quo[fnpll_pkg::CHSPC_W-1:0];
          if ({39'd0, mod_q} > fnpll_pkg::MAX_MODULUS) begin
            ok_q    <= 1'b0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_BAND;
          end
        end
        S_BAND: begin
          dva_q    <= {39'd0, pfd_q} + {39'd0, fnpll_pkg::BAND_RND};
          dvb_q    <= fnpll_pkg::BAND_DIV;
          div_go_q <= 1'b1;
          ret_q    <= S_AMUL1;
          state_q  <= S_WDIV;
        end
        S_AMUL1: begin
          band_q   <= (div_quo > fnpll_pkg::BAND_SAT) ? 8'hFF : div_quo[7:0];
          acc_q    <= '0;
          mcand_q  <= {39'd0, fract_q};
          mplier_q <= fnpll_pkg::MEGA;
          ret_q    <= S_ADIV1;
          state_q  <= S_WMUL;
        end
        S_ADIV1: begin
          dva_q    <= acc_q;
          dvb_q    <= {5'd0, mod_q};
          div_go_q <= 1'b1;
          ret_q    <= S_AMUL2;
          state_q  <= S_WDIV;
        end
        S_AMUL2: begin
          sum_q    <= div_quo;
          acc_q    <= '0;
          mcand_q  <= {48'd0, nint_q};
          mplier_q <= fnpll_pkg::MEGA;
          ret_q    <= S_AMUL3;
          state_q  <= S_WMUL;
        end
        S_AMUL3: begin
          acc_q    <= '0;
          mcand_q  <= acc_q + sum_q;
          mplier_q <= {4'd0, pfdm_q};
          ret_q    <= S_ASHR;
          state_q  <= S_WMUL;
        end
        S_ASHR: begin
          ok_q     <= 1'b1;
          dva_q    <= acc_q >> rfdiv_q;
          dvb_q    <= fnpll_pkg::GIGA;
          div_go_q <= 1'b1;
          ret_q    <= S_FIN;
          state_q  <= S_WDIV;
        end
        S_FIN: begin
          if (out_free) begin
            out_acc_q   <= ok_q;
            out_high_q  <= ok_q & high_q;
            out_int_q   <= ok_q ? nint_q : '0;
            out_fract_q <= ok_q ? fract_q[fnpll_pkg::FR_W-1:0] : '0;
            out_mod_q   <= ok_q ? mod_q[fnpll_pkg::FR_W-1:0] : '0;
            out_r_q     <= ok_q ? r_q[fnpll_pkg::RMAX_W-1:0] : '0;
            out_rfdiv_q <= ok_q ? rfdiv_q : '0;
            out_band_q  <= ok_q ? band_q : '0;
            out_vco_q   <= ok_q ? vco_q : '0;
            out_pfd_q   <= ok_q ? pfd_q : '0;
            out_act_q   <= ok_q ? div_quo[fnpll_pkg::FREQ_W-1:0] : '0;
            state_q     <= S_IDLE;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            state_q <= ret_q;
          end
        end
        S_WMUL: begin
          if (mplier_q == '0) begin
            state_q <= ret_q;
          end else begin
            if (mplier_q[0]) begin
              acc_q <= acc_q + mcand_q;
            end
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = out_acc_q;
  assign out_o.int_value       = out_int_q;
  assign out_o.fract_value     = out_fract_q;
  assign out_o.modulus         = out_mod_q;
  assign out_o.r_count         = out_r_q;
  assign out_o.rf_div_select   = out_rfdiv_q;
  assign out_o.prescaler_high  = out_high_q;
  assign out_o.band_select_div = out_band_q;
  assign out_o.vco_freq_hz     = out_vco_q;
  assign out_o.pfd_hz          = out_pfd_q;
  assign out_o.actual_freq_hz  = out_act_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("solver took a second item while busy");

  a_reject_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.accepted |->
      out_o.int_value == '0 && out_o.modulus == '0 && out_o.vco_freq_hz == '0)
    else $error("rejected item carries nonzero fields");

  a_accept_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.accepted |-> out_o.modulus != '0 && out_o.r_count != '0 &&
      out_o.band_select_div != '0)
    else $error("accepted item with zero modulus, R or band divider");

  a_div_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> state_q == S_WDIV)
    else $error("divider started outside its wait state");
`endif

endmodule
